[hw/rtl/salc_pkg.sv]
`default_nettype none
package salc_pkg;

  localparam int ADDR_BITS  = 16;
  localparam int WORD_BYTES = 8;
  localparam int WORD_W     = 64;
  localparam int MEM_WORD_W = 13;
  localparam int STAMP_W    = 32;
  localparam int SIZE_W     = 4;

  localparam logic FUNC_LOAD  = 1'b0;
  localparam logic FUNC_STORE = 1'b1;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOKUP,
    ST_SCAN,
    ST_VICT,
    ST_WB,
    ST_FILL,
    ST_RD_A,
    ST_RD_B,
    ST_CAP_B,
    ST_WR_A,
    ST_WR_B,
    ST_UPD,
    ST_DONE
  } salc_state_t;

endpackage
`default_nettype wire

[hw/rtl/set_assoc_lru_cache_unit.sv]
`default_nettype none
// set-associative cache with lru replacement (per-line access stamps) in front of a
// 64 KiB backing memory. after reset the backing memory is cleared one 8-byte word a
// cycle while no request is taken. a request looks up the set, reads the addressed
// word and, when the bytes span two words, the next one; a write-back store then
// merges its bytes and writes the word or words back, and the line metadata is
// updated (not on a write-through store miss). a load or write-back store miss adds
// a writeback of the dirty victim and a fill, plus an lru scan and a check of the
// victim when the set has no free way. write-through stores do a read-modify-write
// of one or two backing words, and on a hit repeat it on the line words. all data
// moves through the 8-byte ports of the line and backing memories. one request is
// worked on at a time; the next one is taken while the previous result waits in the output register.
module set_assoc_lru_cache_unit #(
  parameter int SETS        = 64,
  parameter int WAYS        = 4,
  parameter int BLOCK_BYTES = 32
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            cfg_wr_en,
  input  wire logic                            cfg_write_through,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire logic                            in_func,
  input  wire logic [salc_pkg::ADDR_BITS-1:0]  in_address,
  input  wire logic [salc_pkg::SIZE_W-1:0]     in_access_size,
  input  wire logic [salc_pkg::WORD_W-1:0]     in_store_data,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic                                 out_hit,
  output logic      [salc_pkg::WORD_W-1:0]     out_load_data
);
  import salc_pkg::*;

  localparam int OFF_LG   = $clog2(BLOCK_BYTES);
  localparam int BW       = BLOCK_BYTES / WORD_BYTES;
  localparam int BW_LG    = $clog2(BW);
  localparam int SET_LG   = $clog2(SETS);
  localparam int SET_W    = (SET_LG > 0) ? SET_LG : 1;
  localparam int WAY_W    = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int TAG_SH   = OFF_LG + SET_LG;
  localparam int TAG_W    = (ADDR_BITS > TAG_SH) ? ADDR_BITS - TAG_SH : 1;
  localparam int META_W   = TAG_W + 1 + STAMP_W;
  localparam int ROW_W    = WAYS * META_W;
  localparam int LINES    = SETS * WAYS;
  localparam int LW_DEPTH = LINES * BW;
  localparam int LW_W     = (LW_DEPTH > 1) ? $clog2(LW_DEPTH) : 1;
  localparam int CNT_W    = $clog2(BW + 1);
  localparam int MEM_WORDS = 1 << MEM_WORD_W;

  salc_state_t state_r, state_nxt;

  // request registers
  logic                  func_r;
  logic [ADDR_BITS-1:0]  addr_r;
  logic [SIZE_W-1:0]     size_r;
  logic [SIZE_W-1:0]     n_r;
  logic [WORD_W-1:0]     data_r;
  logic [SET_W-1:0]      set_r;
  logic [TAG_W-1:0]      tag_r;

  logic                  wt_r;
  logic [STAMP_W-1:0]    count_r;
  logic [LINES-1:0]      valid_r;
  logic [ROW_W-1:0]      row_r;
  logic                  hit_r;
  logic                  fill_r;
  logic                  tgt_mem_r;
  logic [WAY_W-1:0]      way_r;
  logic [WAY_W-1:0]      scan_r;
  logic [STAMP_W-1:0]    best_r;
  logic [CNT_W-1:0]      cnt_r;
  logic [MEM_WORD_W-1:0] clr_r;
  logic [2*WORD_W-1:0]   buf_r;

  logic                  out_valid_r;
  logic                  out_hit_r;
  logic [WORD_W-1:0]     out_data_r;

  // memory ports
  logic                  meta_we;
  logic [SET_W-1:0]      meta_raddr;
  logic [ROW_W-1:0]      meta_wdata, meta_rdata;
  logic                  line_we;
  logic [LW_W-1:0]       line_waddr, line_raddr;
  logic [WORD_W-1:0]     line_wdata, line_rdata;
  logic                  mem_we;
  logic [MEM_WORD_W-1:0] mem_waddr, mem_raddr;
  logic [WORD_W-1:0]     mem_wdata, mem_rdata;

  salc_ram #(.WIDTH(ROW_W), .DEPTH(SETS), .AW(SET_W)) u_meta (
    .clk(clk), .we(meta_we), .waddr(set_r), .wdata(meta_wdata),
    .raddr(meta_raddr), .rdata(meta_rdata)
  );

  salc_ram #(.WIDTH(WORD_W), .DEPTH(LW_DEPTH), .AW(LW_W)) u_line (
    .clk(clk), .we(line_we), .waddr(line_waddr), .wdata(line_wdata),
    .raddr(line_raddr), .rdata(line_rdata)
  );

  salc_ram #(.WIDTH(WORD_W), .DEPTH(MEM_WORDS), .AW(MEM_WORD_W)) u_back (
    .clk(clk), .we(mem_we), .waddr(mem_waddr), .wdata(mem_wdata),
    .raddr(mem_raddr), .rdata(mem_rdata)
  );

  // request decode at the input
  logic [SIZE_W-1:0] in_size_c, in_n_c;
  logic [7:0]        in_room_c;
  logic [SET_W-1:0]  in_set_c;
  logic [TAG_W-1:0]  in_tag_c;

  always_comb begin
    in_size_c = (in_access_size > SIZE_W'(WORD_BYTES)) ? SIZE_W'(WORD_BYTES) : in_access_size;
    in_room_c = 8'(BLOCK_BYTES) - 8'(32'(in_address) & 32'(BLOCK_BYTES - 1));
    in_n_c    = (8'(in_size_c) > in_room_c) ? SIZE_W'(in_room_c) : in_size_c;
    in_set_c  = SET_W'((32'(in_address) >> OFF_LG) & 32'(SETS - 1));
    in_tag_c  = TAG_W'(32'(in_address) >> TAG_SH);
  end

  logic accept;
  assign in_ready = (state_r == ST_IDLE);
  assign accept   = in_valid && in_ready;

  // lookup on the fetched row
  logic [WAYS-1:0]  vset_c;
  logic             hit_c, inv_c;
  logic [WAY_W-1:0] hit_way_c, inv_way_c;

  always_comb begin
    hit_c     = 1'b0;
    inv_c     = 1'b0;
    hit_way_c = '0;
    inv_way_c = '0;
    for (int w = 0; w < WAYS; w++) begin
      vset_c[w] = valid_r[32'(set_r) * WAYS + w];
    end
    for (int w = 0; w < WAYS; w++) begin
      if (!hit_c && vset_c[w] && meta_rdata[w*META_W +: TAG_W] == tag_r) begin
        hit_c     = 1'b1;
        hit_way_c = WAY_W'(w);
      end
      if (!inv_c && !vset_c[w]) begin
        inv_c     = 1'b1;
        inv_way_c = WAY_W'(w);
      end
    end
  end

  logic [STAMP_W-1:0] scan_stamp_c;
  logic               vict_dirty_c;
  logic [TAG_W-1:0]   vict_tag_c;
  assign scan_stamp_c = row_r[32'(scan_r)*META_W + TAG_W + 1 +: STAMP_W];
  assign vict_dirty_c = row_r[32'(way_r)*META_W + TAG_W];
  assign vict_tag_c   = row_r[32'(way_r)*META_W +: TAG_W];

  // addresses
  logic [LW_W-1:0]       line_base_c, line_word_a_c;
  logic [MEM_WORD_W-1:0] wb_word_c, fill_word_c, mem_word_a_c;
  logic                  need_b_c;
  logic                  wt_store_c;

  always_comb begin
    line_base_c   = LW_W'((32'(set_r) * WAYS + 32'(way_r)) * BW);
    line_word_a_c = LW_W'(32'(line_base_c) + ((32'(addr_r) & 32'(BLOCK_BYTES - 1)) >> 3));
    wb_word_c     = MEM_WORD_W'(((32'(vict_tag_c) << TAG_SH) | (32'(set_r) << OFF_LG)) >> 3);
    fill_word_c   = MEM_WORD_W'((32'(addr_r) >> OFF_LG) << BW_LG);
    mem_word_a_c  = addr_r[ADDR_BITS-1:3];
    need_b_c      = (5'(addr_r[2:0]) + 5'(n_r)) > 5'(WORD_BYTES);
    wt_store_c    = (func_r == FUNC_STORE) && wt_r;
  end

  // byte merge for stores and extraction for loads
  logic [2*WORD_W-1:0] merged_c;
  logic [WORD_W-1:0]   load_c;

  always_comb begin
    logic [4:0] jj;
    logic [2:0] sel;
    logic [4:0] p;
    merged_c = buf_r;
    load_c   = '0;
    for (int pos = 0; pos < 2 * WORD_BYTES; pos++) begin
      jj  = 5'(pos) - 5'(addr_r[2:0]);
      sel = 3'(size_r - 4'd1 - jj[3:0]);
      if (5'(pos) >= 5'(addr_r[2:0]) && jj < 5'(n_r)) begin
        merged_c[pos*8 +: 8] = data_r[32'(sel)*8 +: 8];
      end
    end
    for (int s = 0; s < WORD_BYTES; s++) begin
      p = 5'(addr_r[2:0]) + 5'(n_r) - 5'd1 - 5'(s);
      if (4'(s) < n_r) begin
        load_c[s*8 +: 8] = buf_r[32'(p)*8 +: 8];
      end
    end
  end

  // updated metadata row
  always_comb begin
    logic dirty_v;
    meta_wdata = row_r;
    if (func_r == FUNC_STORE && !wt_r) begin
      dirty_v = 1'b1;
    end else if (fill_r) begin
      dirty_v = 1'b0;
    end else begin
      dirty_v = vict_dirty_c;
    end
    meta_wdata[32'(way_r)*META_W +: META_W] = {count_r, dirty_v, tag_r};
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: if (clr_r == MEM_WORD_W'(MEM_WORDS - 1)) state_nxt = ST_IDLE;
      ST_IDLE:  if (accept) state_nxt = ST_LOOKUP;
      ST_LOOKUP: begin
        if (wt_store_c || hit_c) begin
          state_nxt = ST_RD_A;
        end else if (inv_c) begin
          state_nxt = ST_FILL;
        end else if (WAYS > 1) begin
          state_nxt = ST_SCAN;
        end else begin
          state_nxt = ST_VICT;
        end
      end
      ST_SCAN:  if (scan_r == WAY_W'(WAYS - 1)) state_nxt = ST_VICT;
      ST_VICT:  state_nxt = vict_dirty_c ? ST_WB : ST_FILL;
      ST_WB:    if (cnt_r == CNT_W'(BW)) state_nxt = ST_FILL;
      ST_FILL:  if (cnt_r == CNT_W'(BW)) state_nxt = ST_RD_A;
      ST_RD_A:  state_nxt = ST_RD_B;
      ST_RD_B:  state_nxt = ST_CAP_B;
      ST_CAP_B: state_nxt = (func_r == FUNC_STORE) ? ST_WR_A : ST_UPD;
      ST_WR_A, ST_WR_B: begin
        if (state_r == ST_WR_A && need_b_c) begin
          state_nxt = ST_WR_B;
        end else if (tgt_mem_r && hit_r) begin
          state_nxt = ST_RD_A;
        end else begin
          state_nxt = ST_UPD;
        end
      end
      ST_UPD:   state_nxt = ST_DONE;
      ST_DONE:  if (!out_valid_r || out_ready) state_nxt = ST_IDLE;
      default:  state_nxt = ST_CLEAR;
    endcase
  end

  // memory controls
  always_comb begin
    meta_we    = 1'b0;
    meta_raddr = in_set_c;
    line_we    = 1'b0;
    line_raddr = line_word_a_c;
    line_waddr = line_word_a_c;
    line_wdata = merged_c[WORD_W-1:0];
    mem_we     = 1'b0;
    mem_raddr  = mem_word_a_c;
    mem_waddr  = mem_word_a_c;
    mem_wdata  = merged_c[WORD_W-1:0];
    case (state_r)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_r;
        mem_wdata = '0;
      end
      ST_WB: begin
        line_raddr = LW_W'(32'(line_base_c) + 32'(cnt_r));
        mem_we     = (cnt_r != '0);
        mem_waddr  = MEM_WORD_W'(32'(wb_word_c) + 32'(cnt_r) - 32'd1);
        mem_wdata  = line_rdata;
      end
      ST_FILL: begin
        mem_raddr  = MEM_WORD_W'(32'(fill_word_c) + 32'(cnt_r));
        line_we    = (cnt_r != '0);
        line_waddr = LW_W'(32'(line_base_c) + 32'(cnt_r) - 32'd1);
        line_wdata = mem_rdata;
      end
      ST_RD_B: begin
        line_raddr = LW_W'(32'(line_word_a_c) + 32'd1);
        mem_raddr  = MEM_WORD_W'(32'(mem_word_a_c) + 32'd1);
      end
      ST_WR_A: begin
        line_we = !tgt_mem_r;
        mem_we  = tgt_mem_r;
      end
      ST_WR_B: begin
        line_we    = !tgt_mem_r;
        mem_we     = tgt_mem_r;
        line_waddr = LW_W'(32'(line_word_a_c) + 32'd1);
        mem_waddr  = MEM_WORD_W'(32'(mem_word_a_c) + 32'd1);
        line_wdata = merged_c[2*WORD_W-1:WORD_W];
        mem_wdata  = merged_c[2*WORD_W-1:WORD_W];
      end
      ST_UPD: meta_we = !(wt_store_c && !hit_r);
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_r       <= '0;
      wt_r        <= 1'b0;
      count_r     <= '0;
      valid_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_CLEAR) clr_r <= clr_r + 1'b1;
      if (cfg_wr_en) wt_r <= cfg_write_through;
      if (state_r == ST_UPD && !(wt_store_c && !hit_r)) begin
        valid_r[32'(set_r) * WAYS + 32'(way_r)] <= 1'b1;
      end
      if (state_r == ST_DONE && (!out_valid_r || out_ready)) begin
        count_r     <= count_r + 1'b1;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (accept) begin
      func_r <= in_func;
      addr_r <= in_address;
      size_r <= in_size_c;
      n_r    <= in_n_c;
      data_r <= in_store_data;
      set_r  <= in_set_c;
      tag_r  <= in_tag_c;
    end
    case (state_r)
      ST_LOOKUP: begin
        row_r     <= meta_rdata;
        hit_r     <= hit_c;
        fill_r    <= 1'b0;
        cnt_r     <= '0;
        tgt_mem_r <= wt_store_c;
        way_r     <= hit_c ? hit_way_c : (inv_c ? inv_way_c : '0);
        best_r    <= meta_rdata[TAG_W + 1 +: STAMP_W];
        scan_r    <= WAY_W'(1 % WAYS);
      end
      ST_SCAN: begin
        if (scan_stamp_c < best_r) begin
          best_r <= scan_stamp_c;
          way_r  <= scan_r;
        end
        scan_r <= scan_r + 1'b1;
      end
      ST_WB, ST_FILL: begin
        cnt_r  <= (cnt_r == CNT_W'(BW)) ? '0 : cnt_r + 1'b1;
        fill_r <= 1'b1;
      end
      ST_RD_B:  buf_r[WORD_W-1:0]        <= tgt_mem_r ? mem_rdata : line_rdata;
      ST_CAP_B: buf_r[2*WORD_W-1:WORD_W] <= tgt_mem_r ? mem_rdata : line_rdata;
      ST_WR_A, ST_WR_B: begin
        // second pass updates the line on a write-through hit
        if (state_nxt == ST_RD_A) tgt_mem_r <= 1'b0;
      end
      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_hit_r  <= hit_r;
          out_data_r <= (func_r == FUNC_LOAD) ? load_c : '0;
        end
      end
      default: ;
    endcase
  end

  assign out_valid     = out_valid_r;
  assign out_hit       = out_hit_r;
  assign out_load_data = out_data_r;

endmodule
`default_nettype wire

[hw/rtl/salc_ram.sv]
`default_nettype none
module salc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire
